### design/lpg_pkg.sv
// Shared types and widths for the line pixel generator.
// No dependencies; imported by lpg_ctrl, lpg_datapath and the top level.
`timescale 1ns / 1ps

package lpg_pkg;

  localparam int COORD_W           = 13;    // signed endpoint / pixel coordinate
  localparam int CFG_W             = 13;    // surface size registers
  localparam int COLOR_W           = 32;
  localparam int ADDR_W            = 24;
  localparam int MAX_DIMENSION_DEF = 4096;

  // func codes on the input channel
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // register indexes on the config port
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load_line;  // start word: latch a new line
    logic step_pix;   // step word: stage one pixel, advance the walker
    logic load_out;   // move staged pixel into the output register
  } lpg_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic active;     // a line is being walked
  } lpg_status_t;

endpackage

### design/line_pixel_generator_unit.sv
// Top level of the line pixel generator: controller plus datapath.
// Depends on lpg_pkg, lpg_ctrl and lpg_datapath.
//
// Usage:
//  - Input channel (in_valid/in_ready): a word with func = 0 starts a new line
//    from (start_x,start_y) to (end_x,end_y) in line_color and yields nothing;
//    a word with func = 1 yields the next pixel of the live line, or nothing
//    when no line is live. A start drops any line in progress.
//  - Output channel (out_valid/out_ready): one word per pixel with its
//    coordinates, frame buffer address, color, last_pixel and off_surface.
//  - Config port: cfg_write with cfg_index 0 (width) or 1 (height) and
//    cfg_data; write only while the block is idle.
//  - Pipeline: a step word is held in the pixel stage, then moves to the
//    output register with the address multiply ahead of it.
//  - Throughput: one word per cycle sustained while out_ready is high; the
//    minor axis walks by one remainder add/compare per pixel and the address
//    multiply has its own stage, so both stages take a word each cycle.
//  - Stall: the output register holds its word; the pixel stage fills behind
//    it and in_ready drops once both are full.
//  - Reset: surface 640 x 480, no live line, both stages empty.
`timescale 1ns / 1ps

module line_pixel_generator_unit #(
  parameter int MAX_DIMENSION = lpg_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [lpg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                func,
  input  logic signed [lpg_pkg::COORD_W-1:0]  start_x,
  input  logic signed [lpg_pkg::COORD_W-1:0]  start_y,
  input  logic signed [lpg_pkg::COORD_W-1:0]  end_x,
  input  logic signed [lpg_pkg::COORD_W-1:0]  end_y,
  input  logic [lpg_pkg::COLOR_W-1:0]         line_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lpg_pkg::COORD_W-1:0]  pixel_x,
  output logic signed [lpg_pkg::COORD_W-1:0]  pixel_y,
  output logic [lpg_pkg::ADDR_W-1:0]          pixel_address,
  output logic [lpg_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                last_pixel,
  output logic                                off_surface
);
  import lpg_pkg::*;

  lpg_cmd_t    cmd;     // stage load strobes
  lpg_status_t status;  // line live flag

  // handshakes and stage occupancy
  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // line setup, walker, pixel and address stages, surface registers
  lpg_datapath #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .line_color    (line_color),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel),
    .off_surface   (off_surface)
  );

endmodule

### design/lpg_ctrl.sv
// Handshake controller for the line pixel generator: tracks occupancy of the
// pixel stage and the output register. Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  output logic                out_valid,
  input  logic                out_ready,
  output lpg_pkg::lpg_cmd_t   cmd,
  input  lpg_pkg::lpg_status_t status
);
  import lpg_pkg::*;

  // bit 0: pixel stage full, bit 1: output register full
  localparam logic [1:0] ST_EMPTY  = 2'd0;
  localparam logic [1:0] ST_STAGED = 2'd1;
  localparam logic [1:0] ST_OUT    = 2'd2;
  localparam logic [1:0] ST_BOTH   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       stage_full;
  logic       out_full;
  logic       out_free;
  logic       accept;
  logic       stage_next;
  logic       out_next;

  always_comb begin
    case (state)
      ST_EMPTY: begin
        stage_full = 1'b0;
        out_full   = 1'b0;
      end
      ST_STAGED: begin
        stage_full = 1'b1;
        out_full   = 1'b0;
      end
      ST_OUT: begin
        stage_full = 1'b0;
        out_full   = 1'b1;
      end
      ST_BOTH: begin
        stage_full = 1'b1;
        out_full   = 1'b1;
      end
      default: begin
        stage_full = 1'b0;
        out_full   = 1'b0;
      end
    endcase
  end

  assign out_free  = !out_full || out_ready;
  assign in_ready  = !stage_full || out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_full;

  assign cmd.load_line = accept && (func == FUNC_START);
  assign cmd.step_pix  = accept && (func == FUNC_STEP) && status.active;
  assign cmd.load_out  = stage_full && out_free;

  assign stage_next = cmd.step_pix || (stage_full && !cmd.load_out);
  assign out_next   = cmd.load_out || (out_full && !out_ready);

  always_comb begin
    case ({out_next, stage_next})
      2'b00:   state_next = ST_EMPTY;
      2'b01:   state_next = ST_STAGED;
      2'b10:   state_next = ST_OUT;
      2'b11:   state_next = ST_BOTH;
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // a step word only stages a pixel when a line is live
  a_step_needs_line: assert property (@(posedge clk) disable iff (rst)
    cmd.step_pix |-> status.active) else $error("pixel staged with no active line");

  // a pixel moved out shows up as a valid word next cycle
  a_load_shows_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid) else $error("output word lost after load");

  // a staged pixel that cannot move on is kept
  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (stage_full && !cmd.load_out) |=> (state == ST_STAGED || state == ST_BOTH))
    else $error("staged pixel dropped");

endmodule

### design/lpg_datapath.sv
// Datapath for the line pixel generator: line setup, incremental minor-axis
// walker, pixel stage and address multiply. Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_datapath #(
  parameter int MAX_DIMENSION = lpg_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lpg_pkg::lpg_cmd_t                   cmd,
  output lpg_pkg::lpg_status_t                status,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [lpg_pkg::CFG_W-1:0]           cfg_data,
  input  logic signed [lpg_pkg::COORD_W-1:0]  start_x,
  input  logic signed [lpg_pkg::COORD_W-1:0]  start_y,
  input  logic signed [lpg_pkg::COORD_W-1:0]  end_x,
  input  logic signed [lpg_pkg::COORD_W-1:0]  end_y,
  input  logic [lpg_pkg::COLOR_W-1:0]         line_color,
  output logic signed [lpg_pkg::COORD_W-1:0]  pixel_x,
  output logic signed [lpg_pkg::COORD_W-1:0]  pixel_y,
  output logic [lpg_pkg::ADDR_W-1:0]          pixel_address,
  output logic [lpg_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                last_pixel,
  output logic                                off_surface
);
  import lpg_pkg::*;

  localparam int RW = $clog2(MAX_DIMENSION);   // on-surface row / column
  localparam int DW = RW + 1;                  // clamped dimension
  localparam int DIFF_W = COORD_W + 1;
  localparam logic [CFG_W-1:0] MAX_CFG = CFG_W'(MAX_DIMENSION);

  // configuration
  logic [CFG_W-1:0] surface_width;
  logic [CFG_W-1:0] surface_height;
  logic [DW-1:0]    width_cl;
  logic [DW-1:0]    height_cl;

  // line state
  logic                      active;
  logic                      transposed;
  logic signed [COORD_W-1:0] major_now;
  logic signed [COORD_W-1:0] major_last;
  logic signed [COORD_W-1:0] minor_q;     // floor quotient of the minor value
  logic [COORD_W-1:0]        minor_r;     // remainder, 0 <= r < span
  logic [COORD_W-1:0]        span;
  logic [COORD_W-1:0]        step_r;
  logic                      step_neg;
  logic [COLOR_W-1:0]        held_color;

  // pixel stage
  logic signed [COORD_W-1:0] s1_x;
  logic signed [COORD_W-1:0] s1_y;
  logic [RW-1:0]             s1_col;
  logic [RW-1:0]             s1_row;
  logic                      s1_off;
  logic                      s1_last;
  logic [COLOR_W-1:0]        s1_color;

  // setup logic
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic [DIFF_W-1:0]         abs_dx;
  logic [DIFF_W-1:0]         abs_dy;
  logic                      trans_new;
  logic                      x_desc;
  logic                      y_desc;
  logic [DIFF_W-1:0]         span_new;
  logic signed [DIFF_W-1:0]  dmin_new;
  logic [DIFF_W-1:0]         rd_sum;
  logic signed [COORD_W-1:0] maj_first_new;
  logic signed [COORD_W-1:0] maj_last_new;
  logic signed [COORD_W-1:0] min_first_new;

  // walker and pixel logic
  logic [DIFF_W-1:0]         r_sum;
  logic                      r_carry;
  logic [COORD_W-1:0]        r_next;
  logic [COORD_W-1:0]        q_adj;
  logic signed [COORD_W-1:0] minor_trunc;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic                      off_now;
  logic                      last_now;
  logic [COORD_W-1:0]        row_full;
  logic [RW+DW-1:0]          addr_sum;

  assign width_cl  = (surface_width  > MAX_CFG) ? DW'(MAX_DIMENSION) : DW'(surface_width);
  assign height_cl = (surface_height > MAX_CFG) ? DW'(MAX_DIMENSION) : DW'(surface_height);

  // line setup: major axis is the longer one, ordered so the major coord rises
  assign dx       = DIFF_W'(start_x) - DIFF_W'(end_x);
  assign dy       = DIFF_W'(start_y) - DIFF_W'(end_y);
  assign abs_dx   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign abs_dy   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign trans_new = abs_dx < abs_dy;
  assign x_desc   = !dx[DIFF_W-1] && (dx != '0);
  assign y_desc   = !dy[DIFF_W-1] && (dy != '0);
  assign span_new = trans_new ? abs_dy : abs_dx;

  always_comb begin
    if (trans_new) begin
      dmin_new      = y_desc ? dx : -dx;
      maj_first_new = y_desc ? end_y : start_y;
      maj_last_new  = y_desc ? start_y : end_y;
      min_first_new = y_desc ? end_x : start_x;
    end else begin
      dmin_new      = x_desc ? dy : -dy;
      maj_first_new = x_desc ? end_x : start_x;
      maj_last_new  = x_desc ? start_x : end_x;
      min_first_new = x_desc ? end_y : start_y;
    end
  end

  // |dmin| <= span, so the per-step quotient is 0 or -1 for a falling minor, 0 or +1 for a rising one
  assign rd_sum = DIFF_W'(dmin_new) + span_new;

  // walker: one remainder add and compare per pixel
  assign r_sum   = DIFF_W'(minor_r) + DIFF_W'(step_r);
  assign r_carry = r_sum >= DIFF_W'(span);
  assign r_next  = r_carry ? COORD_W'(r_sum - DIFF_W'(span)) : COORD_W'(r_sum);
  always_comb begin
    if (step_neg && !r_carry) begin
      q_adj = '1;
    end else if (!step_neg && r_carry) begin
      q_adj = COORD_W'(1);
    end else begin
      q_adj = '0;
    end
  end

  // floor to truncation toward zero
  assign minor_trunc = (minor_q[COORD_W-1] && (minor_r != '0)) ? minor_q + 1'b1 : minor_q;
  assign px = transposed ? minor_trunc : major_now;
  assign py = transposed ? major_now : minor_trunc;
  assign off_now = px[COORD_W-1] || py[COORD_W-1]
                || ($unsigned(px) >= COORD_W'(width_cl))
                || ($unsigned(py) >= COORD_W'(height_cl));
  assign row_full = COORD_W'(height_cl) - COORD_W'(1) - $unsigned(py);
  assign last_now = major_now >= major_last;

  assign status.active = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= CFG_W'(640);
      surface_height <= CFG_W'(480);
      active         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH:  surface_width  <= cfg_data;
          REG_HEIGHT: surface_height <= cfg_data;
          default:    surface_width  <= surface_width;
        endcase
      end
      if (cmd.load_line) begin
        active <= 1'b1;
      end else if (cmd.step_pix && last_now) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      transposed <= trans_new;
      major_now  <= maj_first_new;
      major_last <= maj_last_new;
      minor_q    <= min_first_new;
      minor_r    <= '0;
      span       <= COORD_W'(span_new);
      step_neg   <= dmin_new[DIFF_W-1];
      step_r     <= dmin_new[DIFF_W-1] ? COORD_W'(rd_sum) : COORD_W'(dmin_new);
      held_color <= line_color;
    end else if (cmd.step_pix) begin
      major_now <= major_now + 1'b1;
      minor_q   <= minor_q + q_adj;
      minor_r   <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_pix) begin
      s1_x     <= px;
      s1_y     <= py;
      s1_col   <= px[RW-1:0];
      s1_row   <= row_full[RW-1:0];
      s1_off   <= off_now;
      s1_last  <= last_now;
      s1_color <= held_color;
    end
  end

  // address stage: one multiply and add
  assign addr_sum = (s1_row * width_cl) + (RW+DW)'(s1_col);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_x       <= s1_x;
      pixel_y       <= s1_y;
      pixel_address <= s1_off ? '0 : ADDR_W'(addr_sum);
      pixel_color   <= s1_color;
      last_pixel    <= s1_last;
      off_surface   <= s1_off;
    end
  end

  // remainder must stay below the span while a line is live
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (active && (span != '0)) |-> (minor_r < span)) else $error("walker remainder out of range");

  // the final pixel ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.step_pix && last_now) |=> !active) else $error("line still active after last pixel");

endmodule

### bench/tb_line_pixel_generator_unit.sv
// Self-checking bench for line_pixel_generator_unit: directed lines, then random
// line sequences over several surface sizes, with random stalls on both channels.
// Depends on lpg_pkg and the line_pixel_generator_unit RTL.
`timescale 1ns / 1ps

module tb_line_pixel_generator_unit;
  import lpg_pkg::*;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 75;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
    logic [COLOR_W-1:0]        color;
  } line_word_t;

  // Field order matches the output ports, so a concatenation of them fills it
  typedef struct packed {
    logic signed [COORD_W-1:0] x, y;
    logic [ADDR_W-1:0]         addr;
    logic [COLOR_W-1:0]        color;
    logic                      last, off;
  } pixel_t;

  // Line walker model plus the queue of pixels still owed by the block.
  class pixel_scoreboard;
    logic [CFG_W-1:0]   width_reg, height_reg;
    bit                 line_live, steep;
    int                 major_now, major_first, major_last, minor_first, minor_last;
    logic [COLOR_W-1:0] held_color;
    pixel_t             pixels_due[$];
    int                 errors, lines, pixels, writes;

    function new();
      width_reg   = 13'd640;
      height_reg  = 13'd480;
      line_live   = 1'b0;
      steep       = 1'b0;
      major_now   = 0;
      major_first = 0;
      major_last  = 0;
      minor_first = 0;
      minor_last  = 0;
      held_color  = '0;
      errors      = 0;
      lines       = 0;
      pixels      = 0;
      writes      = 0;
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    // Start words latch and order a line; step words queue its next pixel.
    function void note_word(line_word_t w);
      int     ax, ay, bx, by, a_maj, a_min, b_maj, b_min;
      longint span, progress, minor, px, py, wd, ht, lin;
      pixel_t p;
      ax = $signed(w.sx);
      ay = $signed(w.sy);
      bx = $signed(w.ex);
      by = $signed(w.ey);
      if (w.func == FUNC_START) begin
        steep = ((ax > bx) ? ax - bx : bx - ax) < ((ay > by) ? ay - by : by - ay);
        if (steep) begin
          a_maj = ay; a_min = ax; b_maj = by; b_min = bx;
        end else begin
          a_maj = ax; a_min = ay; b_maj = bx; b_min = by;
        end
        if (a_maj > b_maj) begin
          major_first = b_maj; minor_first = b_min;
          major_last  = a_maj; minor_last  = a_min;
        end else begin
          major_first = a_maj; minor_first = a_min;
          major_last  = b_maj; minor_last  = b_min;
        end
        major_now  = major_first;
        held_color = w.color;
        line_live  = 1'b1;
        lines++;
        return;
      end
      if (!line_live) return;

      // exact minor coordinate, whole quotient truncated toward zero
      span     = longint'(major_last) - major_first;
      progress = longint'(major_now) - major_first;
      if (span == 0) minor = minor_first;
      else minor = (longint'(minor_first) * span
                    + (longint'(minor_last) - minor_first) * progress) / span;
      if (steep) begin
        px = minor; py = major_now;
      end else begin
        px = major_now; py = minor;
      end

      wd = (width_reg > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : width_reg;
      ht = (height_reg > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : height_reg;
      p.x     = px[COORD_W-1:0];
      p.y     = py[COORD_W-1:0];
      p.off   = (px < 0) || (px >= wd) || (py < 0) || (py >= ht);
      lin     = p.off ? 0 : px + (ht - 1 - py) * wd;
      p.addr  = lin[ADDR_W-1:0];
      p.color = held_color;
      p.last  = (major_now >= major_last);
      if (p.last) line_live = 1'b0;
      else major_now++;
      pixels_due.push_back(p);
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: pixel with none expected: expected nothing, got x=%0d y=%0d addr=%0h",
                 $time, got.x, got.y, got.addr);
        return;
      end
      want = pixels_due.pop_front();
      pixels++;
      if (!want.off) writes++;
      compare_field("pixel_x", want.x, got.x);
      compare_field("pixel_y", want.y, got.y);
      compare_field("pixel_address", want.addr, got.addr);
      compare_field("pixel_color", want.color, got.color);
      compare_field("last_pixel", want.last, got.last);
      compare_field("off_surface", want.off, got.off);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write;
  logic                      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      func;
  logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
  logic [COLOR_W-1:0]        line_color;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COORD_W-1:0] pixel_x, pixel_y;
  logic [ADDR_W-1:0]         pixel_address;
  logic [COLOR_W-1:0]        pixel_color;
  logic                      last_pixel;
  logic                      off_surface;

  pixel_scoreboard sb;
  logic            calm;          // when set, neither side idles
  int              ready_wait;
  int              ready_hold;
  int              random_words;
  int              words_sent;
  int              cfg_w, cfg_h;  // surface size as last written, for aiming lines

  line_pixel_generator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .line_color    (line_color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_pixel    (last_pixel),
    .off_surface   (off_surface)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: after each accepted pixel, ready may drop for a random stall; never when calm.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b1;
      ready_wait <= 0;
    end else if (out_valid && out_ready) begin
      ready_hold = calm ? 0 : $urandom_range(0, 7);
      ready_wait <= ready_hold;
      out_ready  <= (ready_hold == 0);
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      out_ready  <= (ready_wait == 1);
    end
  end

  // Every accepted output word goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_pixel({pixel_x, pixel_y, pixel_address, pixel_color, last_pixel, off_surface});
  end

  // A random hold-off comes before each word unless calm is set; with none, valid stays up.
  task automatic send_word(line_word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= w.func;
    start_x    <= w.sx;
    start_y    <= w.sy;
    end_x      <= w.ex;
    end_y      <= w.ey;
    line_color <= w.color;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic start_line(int ax, int ay, int bx, int by, logic [COLOR_W-1:0] color);
    line_word_t w;
    w.func  = FUNC_START;
    w.sx    = ax[COORD_W-1:0];
    w.sy    = ay[COORD_W-1:0];
    w.ex    = bx[COORD_W-1:0];
    w.ey    = by[COORD_W-1:0];
    w.color = color;
    send_word(w);
  endtask

  // Endpoint and color fields carry junk on a step; the block must ignore them.
  task automatic step_pixel();
    line_word_t w;
    w.func  = FUNC_STEP;
    w.sx    = COORD_W'($urandom);
    w.sy    = COORD_W'($urandom);
    w.ex    = COORD_W'($urandom);
    w.ey    = COORD_W'($urandom);
    w.color = $urandom;
    send_word(w);
  endtask

  // Drain: all owed pixels back, then a further wait so words that owe nothing clear the block.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Width then height on back-to-back edges, enable held high across both.
  task automatic configure(int w, int h);
    cfg_write <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    sb.write_reg(REG_WIDTH, CFG_W'(w));
    cfg_index <= REG_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    sb.write_reg(REG_HEIGHT, CFG_W'(h));
    cfg_write <= 1'b0;
    cfg_w = w;
    cfg_h = h;
  endtask

  function automatic int clamp13(int v);
    if (v < -4096) return -4096;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Mostly near the surface so on-surface pixels show up; sometimes anywhere.
  function automatic int pick_coord(int lim);
    if ($urandom_range(0, 3) != 0) return clamp13(int'($urandom_range(0, lim + 15)) - 8);
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  // One random line: mostly short and walked to the end, some dropped early,
  // some followed by steps with no live line; the odd long one is cut short.
  task automatic random_line();
    int lim_w, lim_h, d, ax, ay, bx, by, span, steps, roll;
    lim_w = (cfg_w > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : cfg_w;
    lim_h = (cfg_h > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : cfg_h;
    calm <= ($urandom_range(0, 5) == 0);
    roll = $urandom_range(0, 19);
    if (roll < 17) d = $urandom_range(0, 12);
    else if (roll < 19) d = $urandom_range(13, 100);
    else d = 8191;
    ax = pick_coord(lim_w);
    ay = pick_coord(lim_h);
    bx = clamp13(ax + int'($urandom_range(0, 2 * d)) - d);
    by = clamp13(ay + int'($urandom_range(0, 2 * d)) - d);
    span = (bx > ax) ? bx - ax : ax - bx;
    if (((by > ay) ? by - ay : ay - by) > span) span = (by > ay) ? by - ay : ay - by;
    if (span <= 100) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) steps = span + 1;
      else if (roll == 7) steps = span + 1 + $urandom_range(1, 2);
      else steps = $urandom_range(0, span);
    end else begin
      steps = $urandom_range(1, 24);
    end
    start_line(ax, ay, bx, by, $urandom);
    random_words++;
    for (int i = 0; i < steps; i++) begin
      step_pixel();
      if (i <= span) random_words++;
    end
  endtask

  initial begin
    int phase_w[NUM_PHASES];
    int phase_h[NUM_PHASES];
    int phase_start;
    // phase 0 runs on the reset size; zero and oversize registers come later
    phase_w = '{640, 1, 4096, 0, 640, 8191, 5461, 0};
    phase_h = '{480, 1, 4096, 480, 0, 4097, 2730, 0};
    phase_w[NUM_PHASES-1] = $urandom_range(2, 40);
    phase_h[NUM_PHASES-1] = $urandom_range(2, 40);

    sb           = new();
    random_words = 0;
    words_sent   = 0;
    cfg_w        = 640;
    cfg_h        = 480;
    calm       <= 1'b0;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_WIDTH;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    func       <= FUNC_STEP;
    start_x    <= '0;
    start_y    <= '0;
    end_x      <= '0;
    end_y      <= '0;
    line_color <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: step with no line, single point, reversed shallow line,
    // steep line on the surface corner, full-range diagonal dropped early,
    // negative minor truncation, and a line ending at the top coordinates.
    step_pixel();
    start_line(5, 5, 5, 5, 32'hFFFF_FFFF);
    step_pixel();
    step_pixel();
    start_line(3, 1, 0, 0, 32'h0000_0000);
    repeat (4) step_pixel();
    start_line(639, 475, 637, 479, 32'hA5A5_A5A5);
    repeat (5) step_pixel();
    start_line(-4096, 4095, 4095, -4096, 32'h1234_5678);
    repeat (2) step_pixel();
    start_line(-7, 0, 0, -3, 32'h0F0F_0F0F);
    repeat (3) step_pixel();
    start_line(4093, 4095, 4095, 4094, 32'h5A5A_5A5A);
    repeat (3) step_pixel();
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) configure(phase_w[ph], phase_h[ph]);
      phase_start = random_words;
      while (random_words - phase_start < PHASE_WORDS) random_line();
      settle();
    end
    repeat (6) @(posedge clk);

    $display("lines started: %0d, input words: %0d, pixels checked: %0d (%0d on surface)",
             sb.lines, words_sent, sb.pixels, sb.writes);
    $display("surface sizes exercised: %0d, including zero and oversize registers", NUM_PHASES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("line_pixel_generator_unit regression: pass");
    end else begin
      $display("line_pixel_generator_unit regression: fail");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run of this stimulus.
  initial begin
    #5_000_000;
    $display("timeout with %0d pixels still owed", sb.pending());
    $display("line_pixel_generator_unit regression: fail");
    $finish;
  end

endmodule
